// ----- rtl/dbvc_pkg.sv -----
// Package for the dynamic bit-vector compare unit: constants, codes, types and helpers.
`timescale 1ns / 1ps
`default_nettype none

package dbvc_pkg;

    // Largest vector size in bytes; byte addresses at or above the limit do not exist.
    localparam int unsigned MAX_VECTOR_BYTES = 65536;
    localparam int unsigned ADDR_LIMIT_INT   =
        (MAX_VECTOR_BYTES < 65536) ? MAX_VECTOR_BYTES : 65536;
    localparam logic [17:0] ADDR_LIMIT = 18'(ADDR_LIMIT_INT);

    // Configuration port
    localparam int unsigned ADDR_W        = 3;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned THRESHOLD_W   = 20;
    localparam logic        REG_THRESHOLD = 1'b0;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 20'd1;

    // Request kinds
    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_DATA   = 1'b1;

    // Operation codes; code 3 has no operation and answers at once.
    typedef enum logic [1:0] {
        OP_INTERSECT = 2'd0,
        OP_SUBSET    = 2'd1,
        OP_EQUAL     = 2'd2
    } t_op;

    // One result beat.
    typedef struct packed {
        logic [7:0]  and_byte;
        logic        and_valid;
        logic        done_res;
        logic        verdict;
        logic [19:0] support;
        logic [15:0] new_pos;
        logic [16:0] new_len;
        logic        meets_threshold;
    } t_result;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dynamic_bit_vector_compare_unit.sv -----
// Top level of the dynamic bit-vector compare unit (intersect, subset, equality).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// ------    ---------  --------------------  ----------------------------------------------
// input     in         i_valid / o_ready     i_req_type, i_operation, i_a_pos, i_a_len,
//                                            i_b_pos, i_b_len, i_byte_a, i_byte_b
// result    out        o_valid / i_ready     o_and_byte ... o_meets_threshold
// config    in         psel/penable/pwrite   paddr, pwdata, prdata, pready (always high)
//
// Every input beat is worked on in the cycle it is accepted: the header checks, or the AND,
// popcount and running counters of a data beat, sit between the input ports and the result
// register, so one beat is taken per clock while o_ready is high. Its result, if any, is
// registered in the result register, or, while that register still waits, in its
// one-entry skid register. o_ready falls only while the skid register is full, that is
// after two results wait unaccepted downstream. Reset is synchronous and active low; it
// sets the support threshold to one and leaves the unit idle.

module dynamic_bit_vector_compare_unit
    import dbvc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    // Input channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_req_type,
    input  wire logic [1:0]        i_operation,
    input  wire logic [15:0]       i_a_pos,
    input  wire logic [16:0]       i_a_len,
    input  wire logic [15:0]       i_b_pos,
    input  wire logic [16:0]       i_b_len,
    input  wire logic [7:0]        i_byte_a,
    input  wire logic [7:0]        i_byte_b,

    // Result channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_and_byte,
    output logic                   o_and_valid,
    output logic                   o_done_res,
    output logic                   o_verdict,
    output logic [19:0]            o_support,
    output logic [15:0]            o_new_pos,
    output logic [16:0]            o_new_len,
    output logic                   o_meets_threshold,

    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [THRESHOLD_W-1:0] r_threshold;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (cfg_wr && (paddr[2] == REG_THRESHOLD)) begin
            r_threshold <= pwdata[THRESHOLD_W-1:0];
        end
    end

    // Reads beyond the single register return zero.
    always_comb begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = {{(DATA_W-THRESHOLD_W){1'b0}}, r_threshold};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Operation state
    // ------------------------------------------------------------------
    logic [1:0]  r_active_op,     n_active_op;
    logic        r_busy,          n_busy;
    logic [15:0] r_window_start,  n_window_start;
    logic [16:0] r_bytes_left,    n_bytes_left;
    logic [16:0] r_byte_index,    n_byte_index;
    logic [19:0] r_bit_total,     n_bit_total;
    logic [16:0] r_first_nonzero, n_first_nonzero;
    logic [16:0] r_last_nonzero,  n_last_nonzero;
    logic        r_seen_nonzero,  n_seen_nonzero;
    logic        r_verdict,       n_verdict;

    // Result register and skid register
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic    in_fire, out_fire;
    t_result res;
    logic    res_valid;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;

    // Header arithmetic: vector ends and the intersect window.
    logic [17:0] a_end, b_end, win_end, end_min;
    logic [15:0] win_start;
    logic        win_empty;
    logic [16:0] win_len;
    logic        subset_out, equal_diff;

    // Data arithmetic
    logic [7:0]  and_x;
    logic [19:0] pop_sum;
    logic        last_beat;

    always_comb begin
        a_end     = {2'b00, i_a_pos} + {1'b0, i_a_len};
        b_end     = {2'b00, i_b_pos} + {1'b0, i_b_len};
        end_min   = (a_end < b_end) ? a_end : b_end;
        win_end   = (end_min > ADDR_LIMIT) ? ADDR_LIMIT : end_min;
        win_start = (i_a_pos > i_b_pos) ? i_a_pos : i_b_pos;
        win_empty = ({2'b00, win_start} >= win_end);
        win_len   = 17'(win_end - {2'b00, win_start});
        subset_out = (i_a_pos < i_b_pos) || (a_end > b_end);
        equal_diff = (i_a_pos != i_b_pos) || (i_a_len != i_b_len);

        and_x     = i_byte_a & i_byte_b;
        pop_sum   = r_bit_total + {16'd0, pop8(and_x)};
        last_beat = (r_bytes_left == 17'd1);
    end

    always_comb begin
        n_active_op     = r_active_op;
        n_busy          = r_busy;
        n_window_start  = r_window_start;
        n_bytes_left    = r_bytes_left;
        n_byte_index    = r_byte_index;
        n_bit_total     = r_bit_total;
        n_first_nonzero = r_first_nonzero;
        n_last_nonzero  = r_last_nonzero;
        n_seen_nonzero  = r_seen_nonzero;
        n_verdict       = r_verdict;
        res             = '0;
        res_valid       = 1'b0;

        if (in_fire) begin
            if (i_req_type == REQ_HEADER) begin
                // A header always restarts; any running operation is dropped.
                n_active_op     = i_operation;
                n_busy          = 1'b0;
                n_window_start  = 16'd0;
                n_bytes_left    = 17'd0;
                n_byte_index    = 17'd0;
                n_bit_total     = 20'd0;
                n_first_nonzero = 17'd0;
                n_last_nonzero  = 17'd0;
                n_seen_nonzero  = 1'b0;
                n_verdict       = 1'b1;
                case (i_operation) inside
                    OP_INTERSECT: begin
                        if (win_empty) begin
                            res_valid           = 1'b1;
                            res.done_res        = 1'b1;
                            res.meets_threshold = (r_threshold == '0);
                        end else begin
                            n_window_start = win_start;
                            n_bytes_left   = win_len;
                            n_busy         = 1'b1;
                        end
                    end
                    OP_SUBSET, OP_EQUAL: begin
                        if ((i_operation == OP_SUBSET) ? subset_out : equal_diff) begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                        end else if (i_a_len == 17'd0) begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.verdict  = 1'b1;
                        end else begin
                            n_window_start = i_a_pos;
                            n_bytes_left   = i_a_len;
                            n_busy         = 1'b1;
                        end
                    end
                    default: begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                n_byte_index = r_byte_index + 17'd1;
                n_bytes_left = r_bytes_left - 17'd1;
                if (last_beat) begin
                    n_busy = 1'b0;
                end
                if (r_active_op == OP_INTERSECT) begin
                    if (and_x != 8'd0) begin
                        n_bit_total    = pop_sum;
                        n_last_nonzero = r_byte_index;
                        n_seen_nonzero = 1'b1;
                        if (!r_seen_nonzero) begin
                            n_first_nonzero = r_byte_index;
                        end
                    end
                    res_valid     = 1'b1;
                    res.and_byte  = and_x;
                    res.and_valid = 1'b1;
                    if (last_beat) begin
                        res.done_res = 1'b1;
                        if (n_bit_total == 20'd0) begin
                            res.meets_threshold = (r_threshold == '0);
                        end else begin
                            res.support = n_bit_total;
                            res.new_pos = r_window_start + n_first_nonzero[15:0];
                            res.new_len = n_last_nonzero - n_first_nonzero + 17'd1;
                            res.meets_threshold = (n_bit_total >= r_threshold);
                        end
                    end
                end else begin
                    if (r_active_op == OP_SUBSET) begin
                        if (and_x != i_byte_a) begin
                            n_verdict = 1'b0;
                        end
                    end else if (i_byte_a != i_byte_b) begin
                        n_verdict = 1'b0;
                    end
                    if (last_beat) begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.verdict  = n_verdict;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_op     <= 2'd0;
            r_busy          <= 1'b0;
            r_window_start  <= 16'd0;
            r_bytes_left    <= 17'd0;
            r_byte_index    <= 17'd0;
            r_bit_total     <= 20'd0;
            r_first_nonzero <= 17'd0;
            r_last_nonzero  <= 17'd0;
            r_seen_nonzero  <= 1'b0;
            r_verdict       <= 1'b1;
            r_out_valid     <= 1'b0;
            r_skid_valid    <= 1'b0;
        end else begin
            r_active_op     <= n_active_op;
            r_busy          <= n_busy;
            r_window_start  <= n_window_start;
            r_bytes_left    <= n_bytes_left;
            r_byte_index    <= n_byte_index;
            r_bit_total     <= n_bit_total;
            r_first_nonzero <= n_first_nonzero;
            r_last_nonzero  <= n_last_nonzero;
            r_seen_nonzero  <= n_seen_nonzero;
            r_verdict       <= n_verdict;
            if (r_skid_valid) begin
                // No beat is accepted while the skid register is full.
                if (out_fire) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (res_valid) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_and_byte        = r_out.and_byte;
    assign o_and_valid       = r_out.and_valid;
    assign o_done_res        = r_out.done_res;
    assign o_verdict         = r_out.verdict;
    assign o_support         = r_out.support;
    assign o_new_pos         = r_out.new_pos;
    assign o_new_len         = r_out.new_len;
    assign o_meets_threshold = r_out.meets_threshold;

`ifndef ASSERT_OFF
    // The skid register only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while result register empty");

    // An operation in progress always has bytes still to come.
    a_busy_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_bytes_left != 17'd0))
        else $error("busy with no bytes left");

    // No set bits can be counted before a nonzero byte is seen.
    a_total_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen_nonzero |-> (r_bit_total == 20'd0))
        else $error("bit total nonzero without a nonzero byte");

    // Every result is either an AND byte or a final answer.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.and_valid || r_out.done_res))
        else $error("result beat carries neither AND byte nor final answer");

    // A verdict only appears on a final subset or equality answer.
    a_verdict_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict) |-> (r_out.done_res && !r_out.and_valid))
        else $error("verdict outside a final compare answer");
`endif

endmodule

`default_nettype wire
